/* hw/rtl/lzb_pkg.sv */
// Shared constants, types and stage counts of the Lorentz boost pipeline.
package lzb_pkg;

  localparam int unsigned FRONT_LAT  = 3;   // capture, sums, b2 check
  localparam int unsigned SQRT_STEPS = 32;  // one root bit per stage
  localparam int unsigned DEN_LAT    = 2;   // r*r, then divisors
  localparam int unsigned DIV_STEPS  = 96;  // one quotient bit per stage
  localparam int unsigned MUL_LAT    = 3;   // latency of lzb_mul_rs
  localparam int unsigned G_STAGE    = FRONT_LAT + SQRT_STEPS + DEN_LAT + DIV_STEPS + 1;
  localparam int unsigned LAT        = G_STAGE + 2 * MUL_LAT + 1;

  localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;
  localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [31:0] R_MAX     = 32'h8000_0000;
  localparam logic [5:0]  SH_Q      = 6'd46;
  localparam logic [5:0]  SH_T      = 6'd62;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_BIG = 2'd2
  } status_t;

  // Word fields that ride along the long root and divide chains.
  typedef struct packed {
    logic [3:0][31:0] v;    // x, y, z, t
    logic [2:0][31:0] b;    // beta x, y, z
    logic [2:0][63:0] bt;   // beta_i * t
    logic [63:0]      bp;   // beta . v, Q.46
    logic [63:0]      tb;   // t*2^30 + bp
    logic             big;  // b2 not below one
    logic             zero; // b2 is zero
  } side_t;

endpackage

/* hw/rtl/lzb_if.sv */
// Valid/ready channel interfaces for the boost input and result words.
interface lzb_in_if;
  import lzb_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  logic signed [31:0] comp_t;
  logic signed [31:0] beta_x;
  logic signed [31:0] beta_y;
  logic signed [31:0] beta_z;
  modport source (output valid, comp_x, comp_y, comp_z, comp_t, beta_x, beta_y, beta_z,
                  input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, comp_t, beta_x, beta_y, beta_z,
                output ready);
endinterface

interface lzb_out_if;
  import lzb_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] boosted_x;
  logic signed [31:0] boosted_y;
  logic signed [31:0] boosted_z;
  logic signed [31:0] boosted_t;
  status_t            status;
  modport source (output valid, boosted_x, boosted_y, boosted_z, boosted_t, status,
                  input ready);
  modport sink (input valid, boosted_x, boosted_y, boosted_z, boosted_t, status,
                output ready);
endinterface

/* hw/rtl/lzb_mul_rs.sv */
// Pipelined signed 64x64 multiply, round half away from zero, shift, saturate.
module lzb_mul_rs (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic [5:0]         shamt,
  output logic signed [63:0] y
);

  logic        neg1_r, neg2_r;
  logic [5:0]  sh1_r, sh2_r;
  logic [63:0] ma_r, mb_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic [127:0] sum_nxt, rnd_nxt, shf_nxt;
  logic [63:0]  mag_nxt;
  logic signed [63:0] y_r;

  always_comb begin
    sum_nxt = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
            + {p11_r, 64'd0};
    rnd_nxt = sum_nxt + (128'd1 << (sh2_r - 6'd1));
    shf_nxt = rnd_nxt >> sh2_r;
    mag_nxt = (shf_nxt[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : shf_nxt[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[63] ^ b[63];
      sh1_r  <= shamt;
      ma_r   <= a[63] ? 64'(-a) : 64'(a);
      mb_r   <= b[63] ? 64'(-b) : 64'(b);
      neg2_r <= neg1_r;
      sh2_r  <= sh1_r;
      p00_r  <= 64'(ma_r[31:0])  * 64'(mb_r[31:0]);
      p01_r  <= 64'(ma_r[31:0])  * 64'(mb_r[63:32]);
      p10_r  <= 64'(ma_r[63:32]) * 64'(mb_r[31:0]);
      p11_r  <= 64'(ma_r[63:32]) * 64'(mb_r[63:32]);
      y_r    <= neg2_r ? -$signed(mag_nxt) : $signed(mag_nxt);
    end
  end

  assign y = y_r;

endmodule

/* hw/rtl/four_vector_lorentz_boost_unit.sv */
// Top level of the four-vector Lorentz boost pipeline.
// Usage:
//   in_if  carries one word per item: comp_x/y/z/t (Q15.16) and beta_x/y/z (Q1.30).
//   out_if carries one result word per item: boosted_x/y/z/t (Q15.16, saturated)
//   and status (ok, saturated, or beta not below one with the input passed through).
// From acceptance to the result showing on out_if, an item passes the front end, the
// 32-stage square root, the divisor stages, the 96-stage restoring dividers that make
// gamma and (gamma-1)/b2, a rounding stage, two 3-stage split multipliers and a final add stage.
// Throughput is one item per cycle while out_if does not stall: every stage is a register
// with its own valid bit, and the whole chain advances together.
// When the receiver holds out_if.ready low while a result waits, the chain freezes
// and in_if.ready drops in the same cycle; nothing is dropped or repeated, and the
// chain resumes the cycle ready returns.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module four_vector_lorentz_boost_unit (
  input  logic        clk,
  input  logic        rst_n,
  lzb_in_if.sink      in_if,
  lzb_out_if.source   out_if
);
  import lzb_pkg::*;

  localparam int unsigned SQ_IDX = FRONT_LAT + SQRT_STEPS - 1;
  localparam int unsigned G_IDX  = G_STAGE - 1;

  function automatic logic signed [63:0] smul32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return s[63:0];
  endfunction

  // Clamp to 32 bits; report whether clamping happened.
  function automatic logic [32:0] clamp32(input logic signed [63:0] v);
    if (v[63:31] == '0 || v[63:31] == '1) begin
      return {1'b0, v[31:0]};
    end
    return v[63] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
  endfunction

  // Pipeline control: the whole chain advances when the output word is free.
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en          = !vld_r[LAT-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_if.valid};
    end
  end

  // Front end: capture, products, sums, b2 check.
  logic [2:0][31:0]  b_in;
  side_t             s1_side_r, s2_side_r, s3_side_r;
  logic [2:0][63:0]  s1_sq_r, s1_bv_r;
  logic [63:0]       s2_b2_r;
  logic [62:0]       s3_x_r;
  logic signed [63:0] bv_sum_nxt;

  assign b_in       = {in_if.beta_z, in_if.beta_y, in_if.beta_x};
  assign bv_sum_nxt = $signed(s1_bv_r[0]) + $signed(s1_bv_r[1]) + $signed(s1_bv_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r.v     <= {in_if.comp_t, in_if.comp_z, in_if.comp_y, in_if.comp_x};
      s1_side_r.b     <= b_in;
      s1_side_r.bt[0] <= smul32(in_if.beta_x, in_if.comp_t);
      s1_side_r.bt[1] <= smul32(in_if.beta_y, in_if.comp_t);
      s1_side_r.bt[2] <= smul32(in_if.beta_z, in_if.comp_t);
      s1_side_r.bp    <= '0;
      s1_side_r.tb    <= '0;
      s1_side_r.big   <= 1'b0;
      s1_side_r.zero  <= 1'b0;
      s1_sq_r[0] <= smul32(in_if.beta_x, in_if.beta_x);
      s1_sq_r[1] <= smul32(in_if.beta_y, in_if.beta_y);
      s1_sq_r[2] <= smul32(in_if.beta_z, in_if.beta_z);
      s1_bv_r[0] <= smul32(in_if.beta_x, in_if.comp_x);
      s1_bv_r[1] <= smul32(in_if.beta_y, in_if.comp_y);
      s1_bv_r[2] <= smul32(in_if.beta_z, in_if.comp_z);

      s2_side_r.v    <= s1_side_r.v;
      s2_side_r.b    <= s1_side_r.b;
      s2_side_r.bt   <= s1_side_r.bt;
      s2_side_r.bp   <= bv_sum_nxt;
      s2_side_r.tb   <= (64'($signed(s1_side_r.v[3])) <<< 30) + bv_sum_nxt;
      s2_side_r.big  <= 1'b0;
      s2_side_r.zero <= 1'b0;
      s2_b2_r        <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];

      s3_side_r.v    <= s2_side_r.v;
      s3_side_r.b    <= s2_side_r.b;
      s3_side_r.bt   <= s2_side_r.bt;
      s3_side_r.bp   <= s2_side_r.bp;
      s3_side_r.tb   <= s2_side_r.tb;
      s3_side_r.big  <= s2_b2_r >= ONE_Q60;
      s3_side_r.zero <= s2_b2_r == '0;
      s3_x_r         <= 63'((ONE_Q60 - s2_b2_r) << 2);
    end
  end

  // Square root: one result bit per stage.
  logic [63:0] sq_x_r   [SQRT_STEPS];
  logic [63:0] sq_res_r [SQRT_STEPS];
  side_t       sq_side_r[SQRT_STEPS];

  always_ff @(posedge clk) begin
    logic [63:0] xi, ri, bitv, trial;
    if (en) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        xi    = (j == 0) ? {1'b0, s3_x_r} : sq_x_r[j-1];
        ri    = (j == 0) ? 64'd0 : sq_res_r[j-1];
        bitv  = 64'd1 << (62 - 2 * j);
        trial = ri + bitv;
        if (xi >= trial) begin
          sq_x_r[j]   <= xi - trial;
          sq_res_r[j] <= (ri >> 1) + bitv;
        end else begin
          sq_x_r[j]   <= xi;
          sq_res_r[j] <= ri >> 1;
        end
        sq_side_r[j] <= (j == 0) ? s3_side_r : sq_side_r[j-1];
      end
    end
  end

  logic [31:0] root;
  assign root = sq_res_r[SQRT_STEPS-1][31:0];

  // Divisors: r*2^31 for gamma, r*(2^31 + r) for (gamma-1)/b2.
  logic [31:0] dn1_r_r;
  logic [63:0] dn1_rr_r, dn2_dg_r, dn2_d2_r;
  side_t       dn1_side_r, dn2_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dn1_r_r    <= root;
      dn1_rr_r   <= 64'(root) * 64'(root);
      dn1_side_r <= sq_side_r[SQRT_STEPS-1];
      dn2_dg_r   <= {1'b0, dn1_r_r, 31'd0};
      dn2_d2_r   <= {1'b0, dn1_r_r, 31'd0} + dn1_rr_r;
      dn2_side_r <= dn1_side_r;
    end
  end

  // Two restoring dividers side by side: floor(2^95 / den), one bit per stage.
  logic [63:0] dv_rg_r [DIV_STEPS];
  logic [63:0] dv_r2_r [DIV_STEPS];
  logic [63:0] dv_qg_r [DIV_STEPS];
  logic [63:0] dv_q2_r [DIV_STEPS];
  logic [63:0] dv_dg_r [DIV_STEPS];
  logic [63:0] dv_d2_r [DIV_STEPS];
  side_t       dv_side_r[DIV_STEPS];

  always_ff @(posedge clk) begin
    logic [64:0] shg, sh2, dg, d2;
    logic [63:0] qg, q2;
    if (en) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        shg = (j == 0) ? 65'd1 : {dv_rg_r[j-1], 1'b0};
        sh2 = (j == 0) ? 65'd1 : {dv_r2_r[j-1], 1'b0};
        dg  = {1'b0, (j == 0) ? dn2_dg_r : dv_dg_r[j-1]};
        d2  = {1'b0, (j == 0) ? dn2_d2_r : dv_d2_r[j-1]};
        qg  = (j == 0) ? 64'd0 : dv_qg_r[j-1];
        q2  = (j == 0) ? 64'd0 : dv_q2_r[j-1];
        if (shg >= dg) begin
          dv_rg_r[j] <= 64'(shg - dg);
          dv_qg_r[j] <= {qg[62:0], 1'b1};
        end else begin
          dv_rg_r[j] <= shg[63:0];
          dv_qg_r[j] <= {qg[62:0], 1'b0};
        end
        if (sh2 >= d2) begin
          dv_r2_r[j] <= 64'(sh2 - d2);
          dv_q2_r[j] <= {q2[62:0], 1'b1};
        end else begin
          dv_r2_r[j] <= sh2[63:0];
          dv_q2_r[j] <= {q2[62:0], 1'b0};
        end
        dv_dg_r[j]   <= dg[63:0];
        dv_d2_r[j]   <= d2[63:0];
        dv_side_r[j] <= (j == 0) ? dn2_side_r : dv_side_r[j-1];
      end
    end
  end

  // Round the quotients by half: gamma and (gamma-1)/b2 in Q.32.
  logic signed [63:0] g_gamma_r, g_gamma2_r;
  side_t              g_side_r;
  logic [64:0]        qg_inc, q2_inc;

  assign qg_inc = 65'(dv_qg_r[DIV_STEPS-1]) + 65'd1;
  assign q2_inc = 65'(dv_q2_r[DIV_STEPS-1]) + 65'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      g_gamma_r  <= qg_inc[64:1];
      g_gamma2_r <= dv_side_r[DIV_STEPS-1].zero ? 64'sd0 : $signed(q2_inc[64:1]);
      g_side_r   <= dv_side_r[DIV_STEPS-1];
    end
  end

  // Hold gamma2 and the side word alongside the multipliers.
  logic signed [63:0] da_gamma2_r[MUL_LAT];
  side_t              da_side_r  [MUL_LAT];
  side_t              db_side_r  [MUL_LAT];
  logic [2:0][63:0]   db_t2_r    [MUL_LAT];
  logic signed [63:0] db_tt_r    [MUL_LAT];

  // First multiply group: q_i, gamma*beta_i*t and gamma*(t + bp); second group: gamma2*q_i.
  logic signed [63:0] ma_q  [3];
  logic signed [63:0] ma_t2 [3];
  logic signed [63:0] ma_tt;
  logic signed [63:0] mb_t1 [3];

  for (genvar i = 0; i < 3; i++) begin : g_mul
    lzb_mul_rs u_q (
      .clk(clk), .en(en), .a(g_side_r.bp), .b(64'($signed(g_side_r.b[i]))),
      .shamt(SH_Q), .y(ma_q[i])
    );
    lzb_mul_rs u_t2 (
      .clk(clk), .en(en), .a(g_gamma_r), .b(g_side_r.bt[i]),
      .shamt(SH_T), .y(ma_t2[i])
    );
    lzb_mul_rs u_t1 (
      .clk(clk), .en(en), .a(da_gamma2_r[MUL_LAT-1]), .b(ma_q[i]),
      .shamt(SH_Q), .y(mb_t1[i])
    );
  end

  lzb_mul_rs u_tt (
    .clk(clk), .en(en), .a(g_gamma_r), .b(g_side_r.tb),
    .shamt(SH_T), .y(ma_tt)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MUL_LAT; k++) begin
        da_gamma2_r[k] <= (k == 0) ? g_gamma2_r : da_gamma2_r[k-1];
        da_side_r[k]   <= (k == 0) ? g_side_r : da_side_r[k-1];
        db_side_r[k]   <= (k == 0) ? da_side_r[MUL_LAT-1] : db_side_r[k-1];
        db_t2_r[k]     <= (k == 0) ? {ma_t2[2], ma_t2[1], ma_t2[0]} : db_t2_r[k-1];
        db_tt_r[k]     <= (k == 0) ? ma_tt : db_tt_r[k-1];
      end
    end
  end

  // Final sums, clamp and status.
  side_t            fin_side;
  logic [3:0][32:0] fin_c;
  logic [3:0][31:0] out_res_r;
  status_t          out_st_r;

  always_comb begin
    fin_side = db_side_r[MUL_LAT-1];
    for (int i = 0; i < 3; i++) begin
      fin_c[i] = clamp32(add_sat(add_sat(64'($signed(fin_side.v[i])), mb_t1[i]),
                                 $signed(db_t2_r[MUL_LAT-1][i])));
    end
    fin_c[3] = clamp32(db_tt_r[MUL_LAT-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin_side.big) begin
        out_res_r <= fin_side.v;
        out_st_r  <= ST_BIG;
      end else begin
        for (int i = 0; i < 4; i++) begin
          out_res_r[i] <= fin_c[i][31:0];
        end
        out_st_r <= (fin_c[0][32] | fin_c[1][32] | fin_c[2][32] | fin_c[3][32]) ?
                    ST_SAT : ST_OK;
      end
    end
  end

  assign out_if.valid     = vld_r[LAT-1];
  assign out_if.boosted_x = out_res_r[0];
  assign out_if.boosted_y = out_res_r[1];
  assign out_if.boosted_z = out_res_r[2];
  assign out_if.boosted_t = out_res_r[3];
  assign out_if.status    = out_st_r;

  // Hold every valid bit while the chain is frozen.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r)) else $error("valid bits moved during a stall");

  // Root of 4*(1-b2) lands between 2 and 2^31 for a boost below one.
  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQ_IDX] && !sq_side_r[SQRT_STEPS-1].big |-> root >= 32'd2 && root <= R_MAX)
    else $error("square root out of range");

  // Gamma never drops below one.
  a_gamma: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[G_IDX] && !g_side_r.big |-> g_gamma_r >= $signed(ONE_Q32))
    else $error("gamma below one");

  // Zero velocity gives gamma of exactly one and no second-order term.
  a_rest: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[G_IDX] && g_side_r.zero |-> g_gamma_r == $signed(ONE_Q32) && g_gamma2_r == 0)
    else $error("rest frame gamma wrong");

endmodule

/* test/four_vector_lorentz_boost_unit_test.sv */
// Self-checking testbench of the four-vector Lorentz boost unit.
`timescale 1ns / 100ps

module four_vector_lorentz_boost_unit_test;
  import lzb_pkg::*;

  localparam longint INT64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint INT64_MIN = -64'sh7fff_ffff_ffff_ffff - 1;
  localparam int     HOLD_CYCLES = 500;  // long receiver hold-off, well past LAT
  localparam int     N_RANDOM = 1700;

  // One input word plus a flag that makes the sender wait for the pipe to drain.
  typedef struct {
    logic signed [31:0] cx, cy, cz, ct;
    logic signed [31:0] bx, by, bz;
    bit                 drain;
  } vec_word_t;

  typedef struct {
    logic signed [31:0] x, y, z, t;
    status_t            st;
  } boosted_t;

  logic clk;
  logic rst_n;

  lzb_in_if  in_ch ();
  lzb_out_if out_ch ();

  four_vector_lorentz_boost_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  vec_word_t pending_q[$];        // words waiting to be offered
  boosted_t  expected_boost_q[$]; // predicted results, oldest first
  int        n_errors = 0;
  int        n_accepted = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  bit        hold_off = 0;
  bit        calm = 0;            // when set, gaps are skipped for a while

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  function automatic longint sat_add(longint a, longint c);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({c[63], c});
    if (s > $signed({1'b0, INT64_MAX})) return INT64_MAX;
    if (s < $signed({1'b1, INT64_MIN})) return INT64_MIN;
    return s[63:0];
  endfunction

  // Round a*c / 2^sh to nearest, ties away from zero; clamp the magnitude.
  function automatic longint mul_round(longint a, longint c, int sh);
    logic signed [127:0] p;
    logic        [127:0] m;
    bit                  neg;
    neg = (a < 0) != (c < 0);
    p = $signed({{64{a[63]}}, a}) * $signed({{64{c[63]}}, c});
    m = p[127] ? -p : p;
    m = (m + (128'd1 << (sh - 1))) >> sh;
    if (m > {64'd0, INT64_MAX}) m = {64'd0, INT64_MAX};
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic logic [63:0] sqrt_floor(logic [63:0] x);
    logic [63:0] root, trial;
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Low 64 bits of floor(2^k / den).
  function automatic logic [63:0] pow2_div(int k, logic [63:0] den);
    logic [127:0] quo;
    quo = (128'd1 << k) / {64'd0, den};
    return quo[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic boosted_t boost_pred(vec_word_t w);
    longint             v[4], b[3];
    logic signed [31:0] r_out[4];
    longint             gam, gam2, bp, tb, q, t1, t2;
    logic [63:0]        b2, d, root, den;
    bit                 sat;
    boosted_t           o;
    v[0] = longint'(w.cx); v[1] = longint'(w.cy);
    v[2] = longint'(w.cz); v[3] = longint'(w.ct);
    b[0] = longint'(w.bx); b[1] = longint'(w.by); b[2] = longint'(w.bz);
    sat = 0;
    b2 = 0;
    for (int i = 0; i < 3; i++) b2 += 64'(b[i] * b[i]);  // wraps like the hardware sum
    if (b2 >= ONE_Q60) begin
      o.x = w.cx; o.y = w.cy; o.z = w.cz; o.t = w.ct;
      o.st = ST_BIG;
      return o;
    end
    d = ONE_Q60 - b2;
    root = sqrt_floor(d << 2);
    gam = (pow2_div(64, root) + 64'd1) >> 1;
    den = root * (64'h8000_0000 + root);
    gam2 = (b2 == 0) ? 0 : longint'((pow2_div(95, den) + 64'd1) >> 1);
    bp = 0;
    for (int i = 0; i < 3; i++) bp = sat_add(bp, b[i] * v[i]);
    for (int i = 0; i < 3; i++) begin
      q  = mul_round(bp, b[i], 46);
      t1 = mul_round(gam2, q, 46);
      t2 = mul_round(gam, b[i] * v[3], 62);
      r_out[i] = clamp32(sat_add(sat_add(v[i], t1), t2), sat);
    end
    tb = sat_add(v[3] * (64'sd1 << 30), bp);
    r_out[3] = clamp32(mul_round(gam, tb, 62), sat);
    o.x = r_out[0]; o.y = r_out[1]; o.z = r_out[2]; o.t = r_out[3];
    o.st = sat ? ST_SAT : ST_OK;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones, and calm stretches with none at all.
  function automatic int pick_gap();
    int roll;
    if ($urandom_range(0, 150) == 0) calm = !calm;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random component; the shift spreads magnitudes from tiny to full scale.
  function automatic logic signed [31:0] rand_comp();
    logic signed [31:0] c;
    c = $urandom();
    return c >>> $urandom_range(0, 31);
  endfunction

  // Beta component that keeps |beta|^2 below one when all three use it.
  function automatic logic signed [31:0] rand_beta_sub();
    logic signed [31:0] c;
    c = $urandom_range(0, 32'h2000_0000);
    c = c >>> $urandom_range(0, 20);
    return $urandom_range(0, 1) ? -c : c;
  endfunction

  function automatic vec_word_t rand_word();
    vec_word_t w;
    int        mode;
    w.cx = rand_comp(); w.cy = rand_comp(); w.cz = rand_comp(); w.ct = rand_comp();
    w.drain = 0;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      w.bx = rand_beta_sub(); w.by = rand_beta_sub(); w.bz = rand_beta_sub();
    end else if (mode < 78) begin
      w.bx = 0; w.by = 0; w.bz = 0;
    end else if (mode < 90) begin
      // Just under light speed along one axis: huge gamma, saturation likely.
      w.bx = 0; w.by = 0; w.bz = 0;
      case ($urandom_range(0, 2))
        0: w.bx = 32'sh4000_0000 - $urandom_range(1, 4000);
        1: w.by = 32'sh4000_0000 - $urandom_range(1, 4000);
        default: w.bz = 32'sh4000_0000 - $urandom_range(1, 4000);
      endcase
      if ($urandom_range(0, 1)) begin
        w.bx = -w.bx; w.by = -w.by; w.bz = -w.bz;
      end
    end else begin
      w.bx = $urandom(); w.by = $urandom(); w.bz = $urandom();
    end
    return w;
  endfunction

  function automatic vec_word_t make_word(logic signed [31:0] cx, cy, cz, ct, bx, by, bz);
    vec_word_t w;
    w.cx = cx; w.cy = cy; w.cz = cz; w.ct = ct;
    w.bx = bx; w.by = by; w.bz = bz;
    w.drain = 0;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and limit
  // ---------------------------------------------------------------------------

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("** four_vector_lorentz_boost_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: offer the next pending word, hold it while ready is low, predict on
  // acceptance. A word marked drain waits until every predicted result is back.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    vec_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        w = make_word(in_ch.comp_x, in_ch.comp_y, in_ch.comp_z, in_ch.comp_t,
                      in_ch.beta_x, in_ch.beta_y, in_ch.beta_z);
        expected_boost_q.push_back(boost_pred(w));
        n_accepted++;
      end
      // Hold the current word until it is taken.
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && expected_boost_q.size() > 0)) begin
          w = pending_q.pop_front();
          in_ch.comp_x <= w.cx;
          in_ch.comp_y <= w.cy;
          in_ch.comp_z <= w.cz;
          in_ch.comp_t <= w.ct;
          in_ch.beta_x <= w.bx;
          in_ch.beta_y <= w.by;
          in_ch.beta_z <= w.bz;
          in_ch.valid  <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: check each accepted result against the oldest prediction, then
  // decide ready for the next cycle.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    boosted_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_boost_q.size() == 0) begin
          $display("%0t: unexpected result word x=%h y=%h z=%h t=%h status=%s", $time,
                   out_ch.boosted_x, out_ch.boosted_y, out_ch.boosted_z,
                   out_ch.boosted_t, out_ch.status.name());
          n_errors++;
        end else begin
          e = expected_boost_q.pop_front();
          if (out_ch.boosted_x !== e.x) begin
            $display("%0t: boosted_x expected %h actual %h", $time, e.x, out_ch.boosted_x);
            n_errors++;
          end
          if (out_ch.boosted_y !== e.y) begin
            $display("%0t: boosted_y expected %h actual %h", $time, e.y, out_ch.boosted_y);
            n_errors++;
          end
          if (out_ch.boosted_z !== e.z) begin
            $display("%0t: boosted_z expected %h actual %h", $time, e.z, out_ch.boosted_z);
            n_errors++;
          end
          if (out_ch.boosted_t !== e.t) begin
            $display("%0t: boosted_t expected %h actual %h", $time, e.t, out_ch.boosted_t);
            n_errors++;
          end
          if (out_ch.status !== e.st) begin
            $display("%0t: status expected %s actual %s", $time, e.st.name(),
                     out_ch.status.name());
            n_errors++;
          end
        end
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Stall the receiver long enough to fill the pipe and push back on the input.
  initial begin
    wait (n_accepted >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    vec_word_t w;
    in_ch.valid  = 1'b0;
    in_ch.comp_x = '0; in_ch.comp_y = '0; in_ch.comp_z = '0; in_ch.comp_t = '0;
    in_ch.beta_x = '0; in_ch.beta_y = '0; in_ch.beta_z = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;

    // Directed: zero velocity, field extremes, beta at and above one, overflow.
    pending_q.push_back(make_word(0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_word(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                  32'sh7fff_ffff, 0, 0, 0));
    pending_q.push_back(make_word(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                  32'sh8000_0000, 0, 0, 0));
    pending_q.push_back(make_word(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
                                  32'sh0010_0000, 32'sh4000_0000, 0, 0));
    pending_q.push_back(make_word(32'sh1234_5678, 1, -1, 32'sh0765_4321,
                                  32'sh8000_0000, 0, 0));
    pending_q.push_back(make_word(5, 6, 7, 8, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                  32'sh7fff_ffff));
    pending_q.push_back(make_word(5, 6, 7, 8, 32'sh8000_0000, 32'sh8000_0000,
                                  32'sh8000_0000));
    pending_q.push_back(make_word(0, 0, 0, 32'sh0001_0000, 0, 0, 32'sh3fff_ffff));
    pending_q.push_back(make_word(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                  32'sh7fff_ffff, 32'sh3fff_ffff, 0, 0));
    pending_q.push_back(make_word(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                  32'sh8000_0000, 0, -32'sh3fff_ffff, 0));
    pending_q.push_back(make_word(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000,
                                  32'sh0004_0000, 32'sh2000_0000, 32'sh2000_0000,
                                  32'sh2000_0000));
    pending_q.push_back(make_word(32'sh0010_0000, 0, 0, 32'sh0010_0000,
                                  -32'sh2000_0000, 0, 0));
    pending_q.push_back(make_word(32'sh0000_8000, 32'sh0000_0001, 32'sh7fff_0000,
                                  -32'sh0000_8000, 1, -1, 1));
    pending_q.push_back(make_word(-32'sh0100_0000, 32'sh0100_0000, 0, 32'sh7000_0000,
                                  32'sh2d41_3ccc, 32'sh2d41_3ccc, 0));
    pending_q.push_back(make_word(32'sh7fff_ffff, 0, 0, 32'sh7fff_ffff,
                                  -32'sh3fff_ff00, 0, 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      w = rand_word();
      // Pause the sender once until the whole pipe has drained.
      if (i == 900) w.drain = 1;
      pending_q.push_back(w);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() != 0 || in_ch.valid || expected_boost_q.size() != 0);
    repeat (LAT + 20) @(posedge clk);

    if (n_errors == 0 && expected_boost_q.size() == 0) begin
      $display("** four_vector_lorentz_boost_unit: PASSED **");
    end else begin
      $display("** four_vector_lorentz_boost_unit: FAILED **");
    end
    $finish;
  end

endmodule
